FILE: sv/ssui_pkg.sv
// shared constants and types for the sorted set union / intersection block
// no dependencies
package ssui_pkg;

  localparam int unsigned LIST_DEPTH_DEF = 32;
  localparam int unsigned ELEM_W         = 32;

  typedef logic [ELEM_W-1:0] elem_t;

  // tuser bit positions
  localparam int unsigned IN_USER_SEL   = 0;
  localparam int unsigned IN_USER_HAS   = 1;
  localparam int unsigned OUT_USER_EMPT = 0;
  localparam int unsigned OUT_USER_OVF  = 1;

  localparam logic MODE_UNION = 1'b0;
  localparam logic MODE_INTER = 1'b1;

endpackage

FILE: sv/sorted_set_union_intersection.sv
// Loads two ascending lists of signed 32-bit values and emits their union or
// intersection. While loading, in_tready is high and one transfer is taken per
// cycle. The transfer that ends the second of both lists starts the merge, and
// in_tready stays low until it is over. The merge is a two-pointer walk with a
// single signed comparator fed by the two list rams, whose registered read
// is covered by a read state ahead of each compare state; a step waits in
// the compare state while the result side stalls. Results go out through an
// output register, the last one carrying tlast; an empty result is one
// transfer with the empty flag set.
// Depends on ssui_pkg and ssui_ram.
module sorted_set_union_intersection
  import ssui_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // set_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,      // element_value
  input  logic [1:0]  in_tuser,      // list_select, has_element
  input  logic        in_tlast,      // list_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // result_value
  output logic [1:0]  out_tuser,     // result_empty, overflow_seen
  output logic        out_tlast      // result_last
);

  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic          mode_r;
  logic [CW-1:0] fcnt_r, fcnt_nxt, scnt_r, scnt_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic          fdone_r, fdone_nxt, sdone_r, sdone_nxt;
  logic          ovf_r, ovf_nxt;
  logic          pend_v_r, pend_v_nxt;
  elem_t         pend_r, pend_nxt;
  logic          out_v_r, out_v_nxt;
  elem_t         out_d_r, out_d_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_empty_r, out_empty_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  elem_t         rd_a, rd_b;
  logic          f_we, s_we;
  logic          acc, sel, has, cnt_ok;
  logic [CW-1:0] cnt_sel;

  logic          inter, i_ok, j_ok, a_lt, eq;
  logic          emit, adv_i, adv_j, fin, push, stall;
  elem_t         emit_val;

  assign acc     = in_tvalid && in_tready;
  assign sel     = in_tuser[IN_USER_SEL];
  assign has     = in_tuser[IN_USER_HAS];
  assign cnt_sel = sel ? scnt_r : fcnt_r;
  assign cnt_ok  = cnt_sel < CW'(LIST_DEPTH);
  assign f_we    = acc && !sel && !fdone_r && has && cnt_ok;
  assign s_we    = acc && sel && !sdone_r && has && cnt_ok;

  ssui_ram #(.WIDTH(ELEM_W), .DEPTH(LIST_DEPTH)) u_first_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (fcnt_r[AW-1:0]),
    .wdata (in_tdata),
    .raddr (i_r[AW-1:0]),
    .rdata (rd_a)
  );

  ssui_ram #(.WIDTH(ELEM_W), .DEPTH(LIST_DEPTH)) u_second_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (scnt_r[AW-1:0]),
    .wdata (in_tdata),
    .raddr (j_r[AW-1:0]),
    .rdata (rd_b)
  );

  // merge step decision, one signed less-than comparator
  always_comb begin
    inter    = (mode_r == MODE_INTER);
    i_ok     = i_r < fcnt_r;
    j_ok     = j_r < scnt_r;
    a_lt     = $signed(rd_a) < $signed(rd_b);
    eq       = rd_a == rd_b;
    emit     = 1'b0;
    emit_val = rd_b;
    adv_i    = 1'b0;
    adv_j    = 1'b0;
    fin      = 1'b0;
    if (i_ok && j_ok) begin
      if (eq) begin
        emit  = 1'b1;
        adv_i = 1'b1;
        adv_j = 1'b1;
      end else if (a_lt) begin
        emit     = !inter;
        emit_val = rd_a;
        adv_i    = 1'b1;
      end else begin
        emit  = !inter;
        adv_j = 1'b1;
      end
    end else if (!inter && i_ok) begin
      emit     = 1'b1;
      emit_val = rd_a;
      adv_i    = 1'b1;
    end else if (!inter && j_ok) begin
      emit  = 1'b1;
      adv_j = 1'b1;
    end else begin
      fin = 1'b1;
    end
    push  = (emit && pend_v_r) || fin;
    stall = push && out_v_r && !out_tready;
  end

  always_comb begin
    state_nxt     = state_r;
    fcnt_nxt      = fcnt_r;
    scnt_nxt      = scnt_r;
    fdone_nxt     = fdone_r;
    sdone_nxt     = sdone_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_v_nxt     = out_v_r && !out_tready;
    out_d_nxt     = out_d_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    out_ovf_nxt   = out_ovf_r;
    case (state_r)
      S_LOAD: begin
        if (acc && !(sel ? sdone_r : fdone_r)) begin
          if (has && !cnt_ok) begin
            ovf_nxt = 1'b1;
          end
          if (sel) begin
            if (s_we) scnt_nxt = scnt_r + CW'(1);
            if (in_tlast) sdone_nxt = 1'b1;
          end else begin
            if (f_we) fcnt_nxt = fcnt_r + CW'(1);
            if (in_tlast) fdone_nxt = 1'b1;
          end
          if (in_tlast && (sel ? fdone_r : sdone_r)) begin
            state_nxt  = S_READ;
            i_nxt      = '0;
            j_nxt      = '0;
            pend_v_nxt = 1'b0;
          end
        end
      end
      S_READ: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (!stall) begin
          if (push) begin
            out_v_nxt     = 1'b1;
            out_d_nxt     = pend_v_r ? pend_r : '0;
            out_empty_nxt = !pend_v_r;
            out_last_nxt  = fin;
            out_ovf_nxt   = ovf_r;
          end
          if (emit) begin
            pend_v_nxt = 1'b1;
            pend_nxt   = emit_val;
          end
          if (adv_i) i_nxt = i_r + CW'(1);
          if (adv_j) j_nxt = j_r + CW'(1);
          if (fin) begin
            state_nxt  = S_LOAD;
            fcnt_nxt   = '0;
            scnt_nxt   = '0;
            fdone_nxt  = 1'b0;
            sdone_nxt  = 1'b0;
            ovf_nxt    = 1'b0;
            pend_v_nxt = 1'b0;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      mode_r   <= MODE_UNION;
      fcnt_r   <= '0;
      scnt_r   <= '0;
      fdone_r  <= 1'b0;
      sdone_r  <= 1'b0;
      ovf_r    <= 1'b0;
      i_r      <= '0;
      j_r      <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      if (cfg_wr_en) mode_r <= cfg_wr_data;
      fcnt_r   <= fcnt_nxt;
      scnt_r   <= scnt_nxt;
      fdone_r  <= fdone_nxt;
      sdone_r  <= sdone_nxt;
      ovf_r    <= ovf_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r      <= pend_nxt;
    out_d_r     <= out_d_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign in_tready                = (state_r == S_LOAD);
  assign out_tvalid               = out_v_r;
  assign out_tdata                = out_d_r;
  assign out_tlast                = out_last_r;
  assign out_tuser[OUT_USER_EMPT] = out_empty_r;
  assign out_tuser[OUT_USER_OVF]  = out_ovf_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fcnt_r <= CW'(LIST_DEPTH)) && (scnt_r <= CW'(LIST_DEPTH)))
    else $error("list count beyond depth");

  a_merge_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> (fdone_r && sdone_r))
    else $error("merge running before both lists ended");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> ((i_r <= fcnt_r) && (j_r <= scnt_r)))
    else $error("merge pointer past list count");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_empty_r) |-> out_last_r)
    else $error("empty result without last mark");

  a_merge_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD && state_nxt == S_READ) |-> (acc && in_tlast))
    else $error("merge started without a final transfer");

endmodule

FILE: sv/ssui_ram.sv
// generic single write port ram with registered read
// no dependencies
module ssui_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: tb/sv/ssui_checker.sv
// checker for the sorted set union / intersection block: watches the config
// port and both streams, predicts each merge and compares every result transfer
// depends on ssui_pkg
module ssui_checker
  import ssui_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    elem_t value;
    logic  empty;
    logic  last;
    logic  ovf;
  } set_item_t;

  elem_t       first_mem [LIST_DEPTH_DEF];
  elem_t       second_mem [LIST_DEPTH_DEF];
  int unsigned first_len;
  int unsigned second_len;
  logic        first_closed;
  logic        second_closed;
  logic        dropped;
  logic        mode;
  set_item_t   expected_q[$];
  set_item_t   got;
  set_item_t   want;
  int          shown;

  function automatic void add_result(elem_t v, logic empty);
    expected_q.push_back('{v, empty, 1'b0, dropped});
  endfunction

  function automatic void clear_lists();
    first_len     = 0;
    second_len    = 0;
    first_closed  = 1'b0;
    second_closed = 1'b0;
    dropped       = 1'b0;
  endfunction

  function automatic void merge_lists();
    int unsigned i;
    int unsigned j;
    int          start;
    logic        inter;
    set_item_t   tail;
    i = 0;
    j = 0;
    start = expected_q.size();
    inter = (mode == MODE_INTER);
    while (i < first_len && j < second_len) begin
      if ($signed(first_mem[i]) < $signed(second_mem[j])) begin
        if (!inter) add_result(first_mem[i], 1'b0);
        i++;
      end else if ($signed(second_mem[j]) < $signed(first_mem[i])) begin
        if (!inter) add_result(second_mem[j], 1'b0);
        j++;
      end else begin
        add_result(second_mem[j], 1'b0);
        i++;
        j++;
      end
    end
    if (!inter) begin
      while (i < first_len) begin
        add_result(first_mem[i], 1'b0);
        i++;
      end
      while (j < second_len) begin
        add_result(second_mem[j], 1'b0);
        j++;
      end
    end
    if (expected_q.size() == start) add_result('0, 1'b1);
    tail = expected_q.pop_back();
    tail.last = 1'b1;
    expected_q.push_back(tail);
    clear_lists();
  endfunction

  function automatic void load_element(logic sel, logic has, elem_t v, logic fin);
    if (sel ? second_closed : first_closed) return;
    if (has) begin
      if (sel) begin
        if (second_len < LIST_DEPTH_DEF) begin
          second_mem[second_len] = v;
          second_len++;
        end else begin
          dropped = 1'b1;
        end
      end else begin
        if (first_len < LIST_DEPTH_DEF) begin
          first_mem[first_len] = v;
          first_len++;
        end else begin
          dropped = 1'b1;
        end
      end
    end
    if (fin) begin
      if (sel) second_closed = 1'b1;
      else first_closed = 1'b1;
    end
    if (first_closed && second_closed) merge_lists();
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_lists();
      mode = MODE_UNION;
      expected_q.delete();
      fail_count = 0;
      shown = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{out_tdata, out_tuser[OUT_USER_EMPT], out_tlast, out_tuser[OUT_USER_OVF]};
        if (expected_q.size() == 0) begin
          fail_count++;
          if (shown < 40)
            $display("%0t: unexpected result transfer: value %h empty %b last %b ovf %b",
                     $time, got.value, got.empty, got.last, got.ovf);
          shown++;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (shown < 40)
              $display("%0t: result mismatch: expected value %h empty %b last %b ovf %b, %s",
                       $time, want.value, want.empty, want.last, want.ovf,
                       $sformatf("actual value %h empty %b last %b ovf %b",
                                 got.value, got.empty, got.last, got.ovf));
            shown++;
          end
        end
      end
      if (cfg_wr_en) mode = cfg_wr_data;
      if (in_tvalid && in_tready)
        load_element(in_tuser[IN_USER_SEL], in_tuser[IN_USER_HAS], in_tdata, in_tlast);
    end
    pending_results <= expected_q.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
// top of the sorted set union / intersection testbench: clock, reset, list
// stimulus with idle and stall phases, watchdog and verdict
// depends on ssui_pkg, ssui_checker and the block itself
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ssui_pkg::*;

  localparam int WATCH_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 90;
  localparam int SETTLE       = 8;

  typedef struct packed {
    logic        sel;
    logic        has;
    logic [31:0] val;
    logic        last;
  } list_item_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;      // element_value
  logic [1:0]  in_tuser;      // list_select, has_element
  logic        in_tlast;      // list_end
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;     // result_value
  logic [1:0]  out_tuser;     // result_empty, overflow_seen
  logic        out_tlast;     // result_last

  int   fail_count;
  int   pending_results;
  int   idle_pct;
  int   stall_pct;
  int   accepted_items;
  int   phase_start;
  int   watch_cnt;
  logic hold_req;
  logic hold_done;
  int   list_a[$];
  int   list_b[$];

  int   phase_idle [4] = '{0, 59, 0, 32};
  int   phase_stall [4] = '{0, 0, 59, 32};
  logic phase_mode [4] = '{MODE_UNION, MODE_INTER, MODE_UNION, MODE_INTER};

  sorted_set_union_intersection dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  ssui_checker merge_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic send_item(input list_item_t it, input bit counts);
    int         gap;
    logic [1:0] user;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    user = '0;
    user[IN_USER_SEL] = it.sel;
    user[IN_USER_HAS] = it.has;
    in_tvalid <= 1'b1;
    in_tdata  <= it.val;
    in_tuser  <= user;
    in_tlast  <= it.last;
    do @(posedge clk); while (!in_tready);
    if (counts) accepted_items++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic void build_items(input int vals[$], input logic sel, input bit bare,
                                      input int noise_pct, output list_item_t q[$]);
    q = {};
    foreach (vals[n]) begin
      if ($urandom_range(99) < noise_pct) q.push_back('{sel, 1'b0, $urandom, 1'b0});
      q.push_back('{sel, 1'b1, vals[n], (!bare && n == vals.size() - 1)});
    end
    if (bare || vals.size() == 0) q.push_back('{sel, 1'b0, $urandom, 1'b1});
  endfunction

  task automatic send_lists(input int a[$], input int b[$], input bit bare_a,
                            input bit bare_b, input int noise_pct);
    list_item_t qa[$];
    list_item_t qb[$];
    list_item_t stray;
    bit         pick_b;
    build_items(a, 1'b0, bare_a, noise_pct, qa);
    build_items(b, 1'b1, bare_b, noise_pct, qb);
    while (qa.size() + qb.size() > 0) begin
      if (qa.size() == 0 || qb.size() == 0) begin
        // transfers for a list that has already ended are dropped by the block
        if ($urandom_range(99) < noise_pct) begin
          stray = '{(qa.size() != 0), 1'($urandom_range(1)), $urandom,
                    1'($urandom_range(1))};
          send_item(stray, 1'b0);
        end
        pick_b = (qa.size() == 0);
      end else begin
        pick_b = 1'($urandom_range(1));
      end
      if (pick_b) send_item(qb.pop_front(), 1'b1);
      else send_item(qa.pop_front(), 1'b1);
    end
  endtask

  function automatic void make_pool(input bit narrow, input int size, output int pool[$]);
    pool = {};
    repeat (size) pool.push_back(narrow ? int'($urandom_range(400)) - 200 : int'($urandom));
  endfunction

  function automatic void make_list(input int pool[$], input int n, output int vals[$]);
    int tmp[$];
    tmp = pool;
    tmp.shuffle();
    while (tmp.size() > n) tmp.delete(tmp.size() - 1);
    vals = {};
    if ($urandom_range(19) == 0) begin
      // unsorted, with a repeated entry
      if (tmp.size() > 0) tmp.push_back(tmp[0]);
      vals = tmp;
    end else begin
      tmp.sort();
      foreach (tmp[k])
        if (k == 0 || tmp[k] != tmp[k-1]) vals.push_back(tmp[k]);
    end
  endfunction

  task automatic random_pair(input bit force_big);
    int pool_a[$];
    int pool_b[$];
    int a[$];
    int b[$];
    bit narrow;
    int na;
    int nb;
    narrow = 1'($urandom_range(1));
    na = (force_big || $urandom_range(9) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 8);
    nb = ($urandom_range(9) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 8);
    make_pool(narrow, (na > 8 || nb > 8) ? 40 : 12, pool_a);
    if ($urandom_range(3) == 0) make_pool(narrow, 40, pool_b);
    else pool_b = pool_a;
    make_list(pool_a, na, a);
    make_list(pool_b, nb, b);
    send_lists(a, b, $urandom_range(3) == 0, $urandom_range(3) == 0, 10);
  endtask

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    watch_cnt = 0;
    while (watch_cnt < WATCH_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
        watch_cnt = 0;
      else
        watch_cnt++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= MODE_UNION;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    in_tlast    <= 1'b0;
    hold_req    <= 1'b0;
    idle_pct       = 0;
    stall_pct      = 0;
    accepted_items = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty lists, extreme values, empty intersection, unsorted input
    write_mode(MODE_UNION);
    list_a = {};
    list_b = {};
    send_lists(list_a, list_b, 1'b1, 1'b1, 0);
    list_a = {int'(32'h8000_0000), -1, int'(32'h7fff_ffff)};
    list_b = {int'(32'h8000_0000), 0, int'(32'h7fff_ffff)};
    send_lists(list_a, list_b, 1'b0, 1'b1, 0);
    write_mode(MODE_INTER);
    list_a = {1, 2, 3};
    list_b = {4, 5};
    send_lists(list_a, list_b, 1'b0, 1'b0, 50);
    list_a = {9, 3, 3};
    list_b = {3, 9};
    send_lists(list_a, list_b, 1'b1, 1'b0, 0);

    for (int p = 0; p < 4; p++) begin
      write_mode(phase_mode[p]);
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      if (p == 0) hold_req <= 1'b1;
      phase_start = accepted_items;
      random_pair(1'b1);
      while (accepted_items - phase_start < PHASE_ITEMS) random_pair(1'b0);
    end

    wait_idle();
    if (fail_count == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
